FILE: rtl/decimal_text_to_number_assert.svh
// ----------------------------------------------------------------------------
// decimal_text_to_number_assert.svh
// Assertion macros used by the decimal text converter back end.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_NUMBER_ASSERT_SVH
`define DECIMAL_TEXT_TO_NUMBER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked while out of reset.
`define DTN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define DTN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DTN_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTN_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/dtn_pkg.sv
// ----------------------------------------------------------------------------
// dtn_pkg
// Types and constants for the decimal text to number converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtn_pkg;

    // character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int MAX_FRAC_DIGITS_DEF = 11;

    localparam int INT_W  = 32;
    localparam int SIG_W  = 63;          // significand magnitude
    localparam int FRAC_W = 4;

    localparam logic [SIG_W-1:0] SIG_MAX = {SIG_W{1'b1}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic                    is_integer;
        logic signed [INT_W-1:0] int_value;
        logic signed [63:0]      dec_significand;
        logic [FRAC_W-1:0]       frac_digits;
        logic                    saturated;
    } t_out_beat;

    // classified byte, front to back
    typedef struct packed {
        logic       lead;       // leading sign of the string
        logic       is_sign;
        logic       is_minus;
        logic       is_dot;
        logic       is_digit;
        logic [3:0] digit;      // 0 for non-digits
        logic       last;
    } t_cls;

    typedef enum logic [1:0] {
        PH_SIGNS,
        PH_WHOLE,
        PH_FRAC,
        PH_DONE
    } t_phase;

endpackage

FILE: rtl/dtn_front.sv
// ----------------------------------------------------------------------------
// dtn_front
// Accepts text bytes and classifies them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dtn_pkg::t_in_beat i_in_data,
    output logic             o_push,
    output dtn_pkg::t_cls    o_cls,
    input  logic             i_full
);
    import dtn_pkg::*;

    logic r_at_start;
    logic n_at_start;
    logic sign_c;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid & ~i_full;

    assign sign_c = (i_in_data.ch == CH_PLUS) || (i_in_data.ch == CH_MINUS);

    always_comb begin
        o_cls          = '0;
        o_cls.is_sign  = sign_c;
        o_cls.is_minus = (i_in_data.ch == CH_MINUS);
        o_cls.is_dot   = (i_in_data.ch == CH_DOT);
        o_cls.is_digit = (i_in_data.ch >= CH_ZERO) && (i_in_data.ch <= CH_NINE);
        o_cls.digit    = o_cls.is_digit ? i_in_data.ch[3:0] : 4'd0;
        o_cls.lead     = r_at_start & sign_c;
        o_cls.last     = i_in_data.last;
    end

    // a new string starts after every last byte
    assign n_at_start = o_push ? i_in_data.last : r_at_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else begin
            r_at_start <= n_at_start;
        end
    end

endmodule

FILE: rtl/dtn_queue.sv
// ----------------------------------------------------------------------------
// dtn_queue
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtn_pkg::t_cls i_data,
    output logic          o_full,
    output logic          o_valid,
    output dtn_pkg::t_cls o_data,
    input  logic          i_pop
);
    import dtn_pkg::*;

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // depth is a power of two, so pointers wrap on their own
    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/dtn_back.sv
// ----------------------------------------------------------------------------
// dtn_back
// Integer and real accumulation paths plus the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_number_assert.svh"

module dtn_back #(
    parameter int MAX_FRAC_DIGITS = dtn_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dtn_pkg::t_cls     i_cls,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dtn_pkg::t_out_beat o_out_data
);
    import dtn_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);

    // string state
    logic              r_neg, n_neg;
    logic [INT_W-1:0]  r_int, n_int;
    logic              r_int_stop, n_int_stop;
    t_phase            r_phase, n_phase;
    logic              r_dot, n_dot;
    logic [SIG_W-1:0]  r_sig, n_sig;
    logic [CNT_W-1:0]  r_frac, n_frac;
    logic              r_clip, n_clip;

    // result register, magnitudes plus sign
    logic              r_out_valid, n_out_valid;
    logic              r_res_int;
    logic              r_res_neg;
    logic [INT_W-1:0]  r_res_imag;
    logic [SIG_W-1:0]  r_res_smag;
    logic [CNT_W-1:0]  r_res_frac;
    logic              r_res_sat;

    logic              fire;
    logic              fin;
    logic              real_en;
    logic              sig_push;
    logic              frac_step;
    logic [CNT_W-1:0]  frac_inc;
    logic [INT_W-1:0]  int_sum;
    logic [SIG_W+3:0]  sig_sum;
    logic              sig_ovf;
    logic [63:0]       sig_ext;

    // a last byte needs the result register
    assign o_pop   = i_valid & ~(i_cls.last & r_out_valid & i_out_stall);
    assign fire    = o_pop;
    assign fin     = fire & i_cls.last;
    assign real_en = fire & ~i_cls.lead;

    // times ten as shift and add
    assign int_sum = {r_int[INT_W-4:0], 3'b000} + {r_int[INT_W-2:0], 1'b0}
                   + INT_W'(i_cls.digit);
    assign sig_sum = {1'b0, r_sig, 3'b000} + {3'b000, r_sig, 1'b0}
                   + (SIG_W+4)'(i_cls.digit);
    assign sig_ovf = |sig_sum[SIG_W+3:SIG_W];

    assign frac_inc = r_frac + 1'b1;

    // phase: next state
    always_comb begin
        n_phase = r_phase;
        if (real_en) begin
            unique case (r_phase)
                PH_SIGNS: begin
                    if (i_cls.is_dot) begin
                        n_phase = PH_FRAC;
                    end else if (!i_cls.is_sign) begin
                        n_phase = PH_WHOLE;
                    end
                end
                PH_WHOLE: begin
                    if (i_cls.is_dot) begin
                        n_phase = PH_FRAC;
                    end
                end
                PH_FRAC: begin
                    if (frac_inc >= CNT_W'(MAX_FRAC_DIGITS)) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: n_phase = PH_DONE;
                default: n_phase = PH_SIGNS;
            endcase
        end
    end

    // phase: outputs
    always_comb begin
        sig_push  = 1'b0;
        frac_step = 1'b0;
        if (real_en) begin
            unique case (r_phase)
                PH_SIGNS: sig_push = ~i_cls.is_sign & ~i_cls.is_dot;
                PH_WHOLE: sig_push = ~i_cls.is_dot;
                PH_FRAC: begin
                    sig_push  = 1'b1;
                    frac_step = 1'b1;
                end
                PH_DONE: sig_push = 1'b0;
                default: sig_push = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_neg      = (fire & i_cls.lead) ? i_cls.is_minus : r_neg;
        n_dot      = r_dot | (fire & i_cls.is_dot);
        n_int      = r_int;
        n_int_stop = r_int_stop;
        if (real_en && !r_int_stop) begin
            if (!i_cls.is_digit) begin
                n_int_stop = 1'b1;
            end else begin
                n_int      = int_sum;
                n_int_stop = int_sum[INT_W-1];
            end
        end
        n_sig  = r_sig;
        n_clip = r_clip;
        if (sig_push) begin
            if (r_clip || sig_ovf) begin
                n_sig  = SIG_MAX;
                n_clip = 1'b1;
            end else begin
                n_sig = sig_sum[SIG_W-1:0];
            end
        end
        n_frac = frac_step ? frac_inc : r_frac;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fin) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg       <= 1'b0;
            r_int       <= '0;
            r_int_stop  <= 1'b0;
            r_phase     <= PH_SIGNS;
            r_dot       <= 1'b0;
            r_sig       <= '0;
            r_frac      <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (fin) begin
                r_neg      <= 1'b0;
                r_int      <= '0;
                r_int_stop <= 1'b0;
                r_phase    <= PH_SIGNS;
                r_dot      <= 1'b0;
                r_sig      <= '0;
                r_frac     <= '0;
                r_clip     <= 1'b0;
            end else begin
                r_neg      <= n_neg;
                r_int      <= n_int;
                r_int_stop <= n_int_stop;
                r_phase    <= n_phase;
                r_dot      <= n_dot;
                r_sig      <= n_sig;
                r_frac     <= n_frac;
                r_clip     <= n_clip;
            end
        end
    end

    // unused fields of a result are captured as zero
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_res_int  <= ~n_dot;
            r_res_neg  <= n_neg;
            r_res_imag <= n_dot ? '0 : n_int;
            r_res_smag <= n_dot ? n_sig : '0;
            r_res_frac <= n_dot ? n_frac : '0;
            r_res_sat  <= n_dot & n_clip;
        end
    end

    assign sig_ext = {1'b0, r_res_smag};

    assign o_out_valid                = r_out_valid;
    assign o_out_data.is_integer      = r_res_int;
    assign o_out_data.int_value       = r_res_neg ? -r_res_imag : r_res_imag;
    assign o_out_data.dec_significand = r_res_neg ? -sig_ext : sig_ext;
    assign o_out_data.frac_digits     = FRAC_W'(r_res_frac);
    assign o_out_data.saturated       = r_res_sat;

    `DTN_ASSERT(a_frac_bound, i_clk, i_rst_n, r_frac <= CNT_W'(MAX_FRAC_DIGITS), "fraction count past limit")
    `DTN_ASSERT(a_clip_max, i_clk, i_rst_n, r_clip |-> (r_sig == SIG_MAX), "clipped significand not at max")
    `DTN_ASSERT(a_fin_clear, i_clk, i_rst_n, fin |=> (r_phase == PH_SIGNS && !r_dot && r_sig == '0), "string state not cleared")
    `DTN_ASSERT(a_no_overrun, i_clk, i_rst_n, (r_out_valid && i_out_stall) |-> !fin, "result overwritten while stalled")

endmodule

FILE: rtl/decimal_text_to_number.sv
// ----------------------------------------------------------------------------
// decimal_text_to_number
// Converts a number's decimal text, one byte a beat, into an integer result
// or a decimal (signed significand, saturating, and fraction digit count).
// ----------------------------------------------------------------------------
//
//  channel | direction | beat payload          | handshake
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | t_in_beat  ch, last   | i_in_valid / o_in_stall
//  out     | output    | t_out_beat result     | o_out_valid / i_out_stall
//
//  One text byte is taken per cycle, sustained, unless a stalled result holds
//  back a last byte; the rate is set by the back end, which does one
//  multiply-by-ten (shift and add) per byte. A result beat is registered:
//  the last byte of its string passes the queue, then loads the result
//  register. Reset is synchronous, active low; no clearing pass, the block
//  is ready as soon as reset is released.
//  A stalled result blocks only the next last byte; other bytes keep flowing
//  until the two-entry queue fills, then o_in_stall rises.
//
`timescale 1ns / 1ps

module decimal_text_to_number #(
    parameter int MAX_FRAC_DIGITS = dtn_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtn_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtn_pkg::t_out_beat o_out_data
);
    import dtn_pkg::*;

    // front to queue
    logic push;
    t_cls push_cls;
    logic q_full;

    // queue to back
    logic q_valid;
    t_cls q_cls;
    logic q_pop;

    // Front: tracks the start of each string and tags the byte class, so the
    // back end never needs to look at raw characters.
    dtn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cls      (push_cls),
        .i_full     (q_full)
    );

    // Queue: decouples input stall from output stall. Push and pop in one
    // cycle keep a full byte-per-cycle stream going.
    dtn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cls),
        .i_pop   (q_pop)
    );

    // Back: integer and real paths side by side; on the last byte it picks
    // the integer answer when no dot was seen and loads the result register.
    dtn_back #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cls       (q_cls),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: dv/decimal_text_to_number_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_number_checker
// Watches both channels of the text-to-number converter. It parses every
// accepted text byte with its own integer and decimal paths, queues the
// number each string should yield, and compares every result beat with it.
// ----------------------------------------------------------------------------

module decimal_text_to_number_checker #(
    parameter int MAX_FRAC = dtn_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  dtn_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  dtn_pkg::t_out_beat i_out_data,
    output int                 o_err_count,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_reals,
    output int                 o_clipped
);
    import dtn_pkg::*;

    // parse state of the string in flight
    logic        at_start;
    logic        neg;
    logic [31:0] int_acc;
    logic        int_halt;
    t_phase      phase;
    logic        dot_any;
    logic [62:0] sig_acc;
    logic [3:0]  frac_n;
    logic        sig_sat;

    t_out_beat expected_numbers[$];
    int errs    = 0;
    int results = 0;
    int reals   = 0;
    int clipped = 0;

    task automatic clear_parse();
        at_start = 1'b1;
        neg      = 1'b0;
        int_acc  = '0;
        int_halt = 1'b0;
        phase    = PH_SIGNS;
        dot_any  = 1'b0;
        sig_acc  = '0;
        frac_n   = '0;
        sig_sat  = 1'b0;
    endtask

    task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] result %0d %s: got %0h want %0h", $time, results, what, got, want);
        errs++;
    endtask

    // significand x10 + d, saturating at 2^63-1 and sticking there
    task automatic push_sig_digit(input logic [3:0] d);
        logic [63:0] lim;
        lim = (64'h7FFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10;
        if (sig_sat || {1'b0, sig_acc} > lim) begin
            sig_acc = '1;
            sig_sat = 1'b1;
        end else begin
            sig_acc = sig_acc * 63'd10 + 63'(d);
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic fin);
        logic      is_dig;
        logic      is_sgn;
        logic [3:0] dval;
        t_out_beat  num;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sgn = (c == CH_PLUS) || (c == CH_MINUS);
        dval   = is_dig ? 4'(c - CH_ZERO) : 4'd0;

        if (c == CH_DOT)
            dot_any = 1'b1;

        if (at_start && is_sgn) begin
            neg = (c == CH_MINUS);
        end else begin
            // integer path: stops on a non-digit or once the sign bit turns on
            if (!int_halt) begin
                if (!is_dig) begin
                    int_halt = 1'b1;
                end else begin
                    int_acc = int_acc * 32'd10 + 32'(dval);
                    if (int_acc[31])
                        int_halt = 1'b1;
                end
            end
            // decimal path: extra signs skipped, anything else is a digit
            if (phase == PH_SIGNS && !is_sgn)
                phase = PH_WHOLE;
            if (phase == PH_WHOLE) begin
                if (c == CH_DOT)
                    phase = PH_FRAC;
                else
                    push_sig_digit(dval);
            end else if (phase == PH_FRAC) begin
                push_sig_digit(dval);
                frac_n++;
                if (32'(frac_n) >= MAX_FRAC)
                    phase = PH_DONE;
            end
        end
        at_start = 1'b0;

        if (fin) begin
            num = '0;
            if (!dot_any) begin
                num.is_integer = 1'b1;
                num.int_value  = neg ? 32'd0 - int_acc : int_acc;
            end else begin
                num.dec_significand = neg ? 64'd0 - {1'b0, sig_acc} : {1'b0, sig_acc};
                num.frac_digits     = frac_n;
                num.saturated       = sig_sat;
            end
            expected_numbers.push_back(num);
            clear_parse();
        end
    endtask

    task automatic check_number(input t_out_beat got);
        t_out_beat want;
        if (expected_numbers.size() == 0) begin
            flag("beat with no string closed", got.dec_significand, '0);
        end else begin
            want = expected_numbers.pop_front();
            if (got.is_integer !== want.is_integer)
                flag("is_integer", 64'(got.is_integer), 64'(want.is_integer));
            if (got.int_value !== want.int_value)
                flag("int_value", 64'(got.int_value), 64'(want.int_value));
            if (got.dec_significand !== want.dec_significand)
                flag("dec_significand", got.dec_significand, want.dec_significand);
            if (got.frac_digits !== want.frac_digits)
                flag("frac_digits", 64'(got.frac_digits), 64'(want.frac_digits));
            if (got.saturated !== want.saturated)
                flag("saturated", 64'(got.saturated), 64'(want.saturated));
            if (!want.is_integer)
                reals++;
            if (want.saturated)
                clipped++;
        end
        results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            expected_numbers.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_number(i_out_data);
            if (i_in_valid && !i_in_stall)
                parse_char(i_in_data.ch, i_in_data.last);
        end
        o_pending   <= expected_numbers.size();
        o_err_count <= errs;
        o_results   <= results;
        o_reals     <= reals;
        o_clipped   <= clipped;
    end

endmodule

FILE: dv/decimal_text_to_number_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_number_tb
// Feeds number text, byte by byte, into the converter with random gaps on the
// text side and random stalls on the result side. Short hand-picked strings
// come first, then random strings: integers, decimals, long digit runs that
// clip the significand, values at the 32-bit and 63-bit edges, repeated
// signs, corrupted strings and raw byte noise. The checker beside the block
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------

module decimal_text_to_number_tb;
    import dtn_pkg::*;

    localparam int FRAC_LIMIT  = MAX_FRAC_DIGITS_DEF;
    localparam int TEXT_BYTES  = 1600;
    // watchdog bound, many times the worst-case run of the stimulus
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_beat   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_beat  o_out_data;

    int n_errors, n_pending, n_results, n_reals, n_clipped;

    // idle knobs, changed phase by phase; 0 means no idling at all
    int gap_max  = 0;
    int hold_max = 0;

    int bytes_sent   = 0;
    int strings_sent = 0;

    logic [7:0] txt[$];   // string being assembled

    always #5 i_clk = ~i_clk;

    decimal_text_to_number #(
        .MAX_FRAC_DIGITS(FRAC_LIMIT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    decimal_text_to_number_checker #(
        .MAX_FRAC(FRAC_LIMIT)
    ) number_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_err_count (n_errors),
        .o_pending   (n_pending),
        .o_results   (n_results),
        .o_reals     (n_reals),
        .o_clipped   (n_clipped)
    );

    // ------------------------------------------------------------------
    // Result side: before each beat hold stall for a random count, then
    // drop it and wait for the handshake.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        i_out_stall <= 1'b0;
        forever begin
            hold = (hold_max == 0) ? 0 : $urandom_range(0, hold_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall))
                @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[%0t] timeout, %0d results still owed", $time, n_pending);
        $display("decimal_text_to_number_tb: done, errors");
        $finish;
    end

    // One text beat. Valid stays up after acceptance so back-to-back beats
    // need no toggle; a gap lowers it for the drawn count.
    task automatic send_beat(input logic [7:0] c, input logic fin);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{ch: c, last: fin};
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < txt.size(); i++)
            send_beat(txt[i], i == txt.size() - 1);
        strings_sent++;
        txt.delete();
    endtask

    // Hold the text side until every owed result is out. The checker's
    // count is registered, so wait for a clock edge before looking at it.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (n_pending == 0);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_sign();
        case ($urandom_range(0, 3))
            0: txt.push_back(CH_PLUS);
            1: txt.push_back(CH_MINUS);
            default: ;
        endcase
    endtask

    // Builds one random string into txt. Mostly well formed, with edge
    // values and overflow runs weighted in; the rest is junk.
    task automatic build_random();
        int    kind;
        int    pick;
        string edges[10];
        edges = '{"2147483647", "2147483648", "4294967295", "4294967296",
                  "9223372036854775807", "9223372036854775808",
                  "922337203685477580.7", "92233720368547758.08",
                  "99999999999999999999", "214748364.7"};
        kind = $urandom_range(0, 99);
        if (kind < 28) begin
            // plain integer, long ones wrap
            add_sign();
            add_digits($urandom_range(1, 12));
        end else if (kind < 58) begin
            // decimal, fraction may run past the digit limit
            add_sign();
            add_digits($urandom_range(0, 6));
            txt.push_back(CH_DOT);
            add_digits($urandom_range(0, 14));
            if ($urandom_range(0, 3) == 0) begin
                txt.push_back(CH_DOT);
                add_digits($urandom_range(1, 2));
            end
        end else if (kind < 68) begin
            // long digit runs, the longer ones clip the significand
            add_sign();
            add_digits($urandom_range(17, 24));
            if ($urandom_range(0, 1) == 0) begin
                txt.push_back(CH_DOT);
                add_digits($urandom_range(0, 4));
            end
        end else if (kind < 78) begin
            add_sign();
            add_str(edges[$urandom_range(0, 9)]);
        end else if (kind < 86) begin
            // sign runs: past the leading sign, integer path stops, decimal path skips them
            repeat ($urandom_range(1, 4))
                txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            add_digits($urandom_range(0, 5));
            if ($urandom_range(0, 1) == 0) begin
                txt.push_back(CH_DOT);
                add_digits($urandom_range(0, 4));
            end
        end else if (kind < 94) begin
            // well formed with one stray byte dropped in
            add_sign();
            add_digits($urandom_range(1, 6));
            if ($urandom_range(0, 1) == 0) begin
                txt.push_back(CH_DOT);
                add_digits($urandom_range(0, 6));
            end
            pick = $urandom_range(0, txt.size());
            txt.insert(pick, 8'($urandom_range(0, 255)));
        end else begin
            // raw noise, biased toward the characters that matter
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0: txt.push_back(CH_DOT);
                    1: txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    2: txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: txt.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-picked strings, no idling
        add_str("0");      send_text();     // zero
        add_str("9");      send_text();     // top digit
        add_str("-5");     send_text();     // negative integer
        add_str("+.");     send_text();     // sign then dot: decimal zero
        add_str(".");      send_text();     // lone dot
        add_str("1.5");    send_text();
        add_str("-x");     send_text();     // integer path stops at non-digit
        txt.push_back(8'hFF); send_text();  // high byte alone
        txt.push_back(8'h00); send_text();  // null byte alone
        add_str("--3.2");  send_text();     // repeated sign
        add_str("a.9");    send_text();     // non-digit before dot reads as 0

        // sender holds off until the pipe is empty
        drain();

        while (bytes_sent < TEXT_BYTES) begin
            // new idle mix every few dozen strings
            if (strings_sent % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 14;
                endcase
                case ($urandom_range(0, 2))
                    0: hold_max = 0;
                    1: hold_max = 3;
                    default: hold_max = 14;
                endcase
            end
            if (strings_sent % 150 == 75)
                drain();
            build_random();
            send_text();
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d text bytes in %0d strings, no byte gaps to 14-cycle gaps",
                 bytes_sent, strings_sent);
        $display("checked %0d numbers: %0d decimal, %0d with clipped significand",
                 n_results, n_reals, n_clipped);
        if (n_errors == 0) begin
            $display("decimal_text_to_number_tb: done, clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("decimal_text_to_number_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dtn_pkg.sv
rtl/dtn_front.sv
rtl/dtn_queue.sv
rtl/dtn_back.sv
rtl/decimal_text_to_number.sv
dv/decimal_text_to_number_checker.sv
dv/decimal_text_to_number_tb.sv
